>>> hw/rtl/las_pkg.sv
// Shared widths, angle codes, tangent thresholds and stage payload types for the line snapper.
package las_pkg;

    // coordinate and fixed point format
    localparam int COORD_W   = 15;
    localparam int FRAC_BITS = 16;

    // magnitudes of dx/dy fit COORD_W unsigned bits; tangents stay below 4.0
    localparam int TAN_W  = FRAC_BITS + 2;
    localparam int PROD_W = TAN_W + COORD_W;
    localparam int SQR_W  = 2 * COORD_W;

    // radicand up to 3 * (a^2 + b^2); root keeps two spare bits over the coordinate
    localparam int ROOT_W = COORD_W + 2;
    localparam int RAD_W  = 2 * ROOT_W;

    // square root pipeline: root bits resolved per stage and resulting depth
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = (ROOT_W + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

    // angle codes
    typedef enum logic [2:0] {
        ANG_NONE       = 3'd0,
        ANG_HORZ       = 3'd1,
        ANG_THIRTY     = 3'd2,
        ANG_FORTY_FIVE = 3'd3,
        ANG_SIXTY      = 3'd4,
        ANG_VERT       = 3'd5
    } t_angle;

    // payload that rides alongside the square root lanes
    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        t_angle                    angle;
        logic                      neg_x;
        logic                      neg_y;
    } t_side;

    // floor square root, used only at elaboration
    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 to Q(FRAC_BITS), round half up
    function automatic logic [TAN_W-1:0] f_to_frac(input logic [63:0] q30);
        logic [63:0] t;
        t = (q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return t[TAN_W-1:0];
    endfunction

    localparam logic [63:0] Q_ONE = 64'd1 << 30;
    localparam logic [63:0] R2    = f_isqrt(64'd2 << 60);
    localparam logic [63:0] R3    = f_isqrt(64'd3 << 60);
    localparam logic [63:0] R6    = f_isqrt(64'd6 << 60);

    // midpoint tangent table, by pair of neighboring angles
    localparam int N_TAN = 7;
    localparam int TI_15 = 0;   // horizontal / thirty
    localparam int TI_22 = 1;   // horizontal / forty-five
    localparam int TI_37 = 2;   // thirty / forty-five
    localparam int TI_45 = 3;   // thirty / sixty
    localparam int TI_52 = 4;   // forty-five / sixty
    localparam int TI_67 = 5;   // forty-five / vertical
    localparam int TI_75 = 6;   // sixty / vertical

    localparam logic [TAN_W-1:0] TAN_MID [N_TAN] = '{
        f_to_frac(2 * Q_ONE - R3),
        f_to_frac(R2 - Q_ONE),
        f_to_frac((R6 + R3) - (R2 + 2 * Q_ONE)),
        f_to_frac(Q_ONE),
        f_to_frac((R6 + 2 * Q_ONE) - (R2 + R3)),
        f_to_frac(R2 + Q_ONE),
        f_to_frac(2 * Q_ONE + R3)
    };

endpackage

>>> hw/rtl/las_prep.sv
// Front stages: deltas, slope products, angle decision and radicand selection.
module las_prep
    import las_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic                      i_snap_forty_five,
    input  logic                      i_snap_thirty_sixty,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [RAD_W-1:0]          o_rad_x,
    output logic [RAD_W-1:0]          o_rad_y,
    output t_side                     o_side
);

    // stage enables: a stage loads when empty or when its contents move on
    logic w_en1, w_en2, w_en3;
    logic r_s1_v, r_s2_v, r_s3_v;

    assign w_en3   = !r_s3_v || i_ready;
    assign w_en2   = !r_s2_v || w_en3;
    assign w_en1   = !r_s1_v || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_s3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (w_en1) r_s1_v <= i_valid;
            if (w_en2) r_s2_v <= r_s1_v;
            if (w_en3) r_s3_v <= r_s2_v;
        end
    end

    // stage 1: signed deltas and magnitudes
    logic [COORD_W:0] w_dx, w_dy, w_mag_x, w_mag_y;

    assign w_dx    = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
    assign w_dy    = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
    assign w_mag_x = w_dx[COORD_W] ? (~w_dx + 1'b1) : w_dx;
    assign w_mag_y = w_dy[COORD_W] ? (~w_dy + 1'b1) : w_dy;

    logic [COORD_W-1:0]        r_s1_a, r_s1_b;
    logic                      r_s1_neg_x, r_s1_neg_y, r_s1_f45, r_s1_f3060;
    logic signed [COORD_W-1:0] r_s1_sx, r_s1_sy, r_s1_ex, r_s1_ey;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_a     <= w_mag_y[COORD_W-1:0];
            r_s1_b     <= w_mag_x[COORD_W-1:0];
            r_s1_neg_x <= w_dx[COORD_W];
            r_s1_neg_y <= w_dy[COORD_W];
            r_s1_f45   <= i_snap_forty_five;
            r_s1_f3060 <= i_snap_thirty_sixty;
            r_s1_sx    <= i_start_x;
            r_s1_sy    <= i_start_y;
            r_s1_ex    <= i_end_x;
            r_s1_ey    <= i_end_y;
        end
    end

    // stage 2: threshold products and squares
    logic [PROD_W-1:0] n_tb [N_TAN];

    always_comb begin
        for (int i = 0; i < N_TAN; i++) begin
            n_tb[i] = PROD_W'(TAN_MID[i]) * PROD_W'(r_s1_b);
        end
    end

    logic [PROD_W-1:0]         r_s2_tb [N_TAN];
    logic [SQR_W-1:0]          r_s2_aa, r_s2_bb;
    logic [COORD_W-1:0]        r_s2_a;
    logic                      r_s2_neg_x, r_s2_neg_y, r_s2_f45, r_s2_f3060;
    logic signed [COORD_W-1:0] r_s2_sx, r_s2_sy, r_s2_ex, r_s2_ey;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_tb    <= n_tb;
            r_s2_aa    <= SQR_W'(r_s1_a) * SQR_W'(r_s1_a);
            r_s2_bb    <= SQR_W'(r_s1_b) * SQR_W'(r_s1_b);
            r_s2_a     <= r_s1_a;
            r_s2_neg_x <= r_s1_neg_x;
            r_s2_neg_y <= r_s1_neg_y;
            r_s2_f45   <= r_s1_f45;
            r_s2_f3060 <= r_s1_f3060;
            r_s2_sx    <= r_s1_sx;
            r_s2_sy    <= r_s1_sy;
            r_s2_ex    <= r_s1_ex;
            r_s2_ey    <= r_s1_ey;
        end
    end

    // stage 3: slope compares, angle pick, radicands and base point
    logic [N_TAN-1:0]  w_lt;
    logic [PROD_W-1:0] w_a_sh;
    logic [SQR_W:0]    w_sum;
    logic [RAD_W-1:0]  w_s1, w_s2, w_s3;
    t_angle            n_angle;
    logic [RAD_W-1:0]  n_rad_x, n_rad_y;
    t_side             n_side;

    assign w_a_sh = PROD_W'({r_s2_a, {FRAC_BITS{1'b0}}});
    assign w_sum  = {1'b0, r_s2_aa} + {1'b0, r_s2_bb};
    assign w_s1   = RAD_W'(w_sum);
    assign w_s2   = RAD_W'({w_sum, 1'b0});
    assign w_s3   = w_s1 + w_s2;

    always_comb begin
        for (int i = 0; i < N_TAN; i++) begin
            w_lt[i] = w_a_sh < r_s2_tb[i];
        end
    end

    // first allowed angle whose upper midpoint beats the slope
    always_comb begin
        priority if (!r_s2_f45 && !r_s2_f3060) begin
            n_angle = ANG_NONE;
        end else if (!r_s2_f3060) begin
            priority if (w_lt[TI_22]) n_angle = ANG_HORZ;
            else if (w_lt[TI_67])     n_angle = ANG_FORTY_FIVE;
            else                      n_angle = ANG_VERT;
        end else if (!r_s2_f45) begin
            priority if (w_lt[TI_15]) n_angle = ANG_HORZ;
            else if (w_lt[TI_45])     n_angle = ANG_THIRTY;
            else if (w_lt[TI_75])     n_angle = ANG_SIXTY;
            else                      n_angle = ANG_VERT;
        end else begin
            priority if (w_lt[TI_15]) n_angle = ANG_HORZ;
            else if (w_lt[TI_37])     n_angle = ANG_THIRTY;
            else if (w_lt[TI_52])     n_angle = ANG_FORTY_FIVE;
            else if (w_lt[TI_75])     n_angle = ANG_SIXTY;
            else                      n_angle = ANG_VERT;
        end
    end

    // radicands are 4c * (dx^2 + dy^2); base is the point the offset adds to
    always_comb begin
        n_side.angle = n_angle;
        n_side.neg_x = r_s2_neg_x;
        n_side.neg_y = r_s2_neg_y;
        n_rad_x      = '0;
        n_rad_y      = '0;
        unique case (n_angle)
            ANG_NONE: begin
                n_side.base_x = r_s2_ex;
                n_side.base_y = r_s2_ey;
            end
            ANG_HORZ: begin
                n_side.base_x = r_s2_ex;
                n_side.base_y = r_s2_sy;
            end
            ANG_VERT: begin
                n_side.base_x = r_s2_sx;
                n_side.base_y = r_s2_ey;
            end
            ANG_THIRTY: begin
                n_side.base_x = r_s2_sx;
                n_side.base_y = r_s2_sy;
                n_rad_x       = w_s3;
                n_rad_y       = w_s1;
            end
            ANG_FORTY_FIVE: begin
                n_side.base_x = r_s2_sx;
                n_side.base_y = r_s2_sy;
                n_rad_x       = w_s2;
                n_rad_y       = w_s2;
            end
            ANG_SIXTY: begin
                n_side.base_x = r_s2_sx;
                n_side.base_y = r_s2_sy;
                n_rad_x       = w_s1;
                n_rad_y       = w_s3;
            end
            default: begin
                n_side.base_x = r_s2_ex;
                n_side.base_y = r_s2_ey;
            end
        endcase
    end

    logic [RAD_W-1:0] r_s3_rad_x, r_s3_rad_y;
    t_side            r_s3_side;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_rad_x <= n_rad_x;
            r_s3_rad_y <= n_rad_y;
            r_s3_side  <= n_side;
        end
    end

    assign o_rad_x = r_s3_rad_x;
    assign o_rad_y = r_s3_rad_y;
    assign o_side  = r_s3_side;

endmodule

>>> hw/rtl/las_sqrt.sv
// Pipelined two-lane floor square root, digit recurrence, side payload carried along.
module las_sqrt
    import las_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RAD_W-1:0]  i_rad_x,
    input  logic [RAD_W-1:0]  i_rad_y,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROOT_W-1:0] o_root_x,
    output logic [ROOT_W-1:0] o_root_y,
    output t_side             o_side
);

    localparam int LAST = SQ_STAGES - 1;

    // partial remainder, partial root and radicand bits still to consume
    typedef struct packed {
        logic [ROOT_W:0]   rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sq;

    // one root bit: bring down two radicand bits, try 4*root+1
    function automatic t_sq f_step(input t_sq s);
        logic [ROOT_W+2:0] cur;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;
        t_sq               o;
        cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        diff  = cur - trial;
        o.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            o.rem  = diff[ROOT_W:0];
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur[ROOT_W:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [SQ_STAGES:0] w_en;
    logic               r_v [SQ_STAGES];
    t_sq                n_sq [SQ_STAGES][2];
    t_sq                r_sq [SQ_STAGES][2];
    t_side              r_side [SQ_STAGES];

    assign w_en[SQ_STAGES] = i_ready;
    assign o_ready         = w_en[0];
    assign o_valid         = r_v[LAST];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic  w_v_in;
        t_sq   w_sq_in [2];
        t_side w_side_in;

        assign w_en[k] = !r_v[k] || w_en[k+1];

        // stage inputs: the request ports for the first stage, else the stage before
        if (k == 0) begin : g_first
            assign w_v_in     = i_valid;
            assign w_sq_in[0] = {{(ROOT_W + 1){1'b0}}, {ROOT_W{1'b0}}, i_rad_x};
            assign w_sq_in[1] = {{(ROOT_W + 1){1'b0}}, {ROOT_W{1'b0}}, i_rad_y};
            assign w_side_in  = i_side;
        end else begin : g_next
            assign w_v_in     = r_v[k-1];
            assign w_sq_in[0] = r_sq[k-1][0];
            assign w_sq_in[1] = r_sq[k-1][1];
            assign w_side_in  = r_side[k-1];
        end

        // valid bit per stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_v_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            // steps resolved in this stage
            always_comb begin
                t_sq w;
                w = w_sq_in[l];
                for (int j = 0; j < SQ_PER_STAGE; j++) begin
                    if (k * SQ_PER_STAGE + j < ROOT_W) w = f_step(w);
                end
                n_sq[k][l] = w;
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k]) r_sq[k][l] <= n_sq[k][l];
            end
        end

        // side payload
        always_ff @(posedge i_clk) begin
            if (w_en[k]) r_side[k] <= w_side_in;
        end
    end

    assign o_root_x = r_sq[LAST][0].root;
    assign o_root_y = r_sq[LAST][1].root;
    assign o_side   = r_side[LAST];

endmodule

>>> hw/rtl/las_finish.sv
// Output stage: round the roots, apply signs, add to the start point and clamp.
module las_finish
    import las_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ROOT_W-1:0]         i_root_x,
    input  logic [ROOT_W-1:0]         i_root_y,
    input  t_side                     i_side,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_snapped_x,
    output logic signed [COORD_W-1:0] o_snapped_y,
    output logic [2:0]                o_chosen_angle,
    output logic                      o_saturated
);

    localparam int SUM_W = ROOT_W + 2;
    localparam logic signed [SUM_W-1:0] LIM_HI =
        {{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] LIM_LO =
        {{(SUM_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    logic r_valid;
    logic w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // offsets: round half up of the root, then signed
    logic [ROOT_W:0]          w_rx1, w_ry1;
    logic signed [SUM_W-1:0]  w_kx, w_ky, w_bx, w_by, w_sum_x, w_sum_y;
    logic                     w_diag, w_hi_x, w_lo_x, w_hi_y, w_lo_y;

    assign w_rx1 = {1'b0, i_root_x} + 1'b1;
    assign w_ry1 = {1'b0, i_root_y} + 1'b1;
    assign w_kx  = {{(SUM_W - ROOT_W){1'b0}}, w_rx1[ROOT_W:1]};
    assign w_ky  = {{(SUM_W - ROOT_W){1'b0}}, w_ry1[ROOT_W:1]};
    assign w_bx  = {{(SUM_W - COORD_W){i_side.base_x[COORD_W-1]}}, i_side.base_x};
    assign w_by  = {{(SUM_W - COORD_W){i_side.base_y[COORD_W-1]}}, i_side.base_y};

    assign w_sum_x = i_side.neg_x ? (w_bx - w_kx) : (w_bx + w_kx);
    assign w_sum_y = i_side.neg_y ? (w_by - w_ky) : (w_by + w_ky);

    assign w_hi_x = w_sum_x > LIM_HI;
    assign w_lo_x = w_sum_x < LIM_LO;
    assign w_hi_y = w_sum_y > LIM_HI;
    assign w_lo_y = w_sum_y < LIM_LO;

    assign w_diag = (i_side.angle == ANG_THIRTY) || (i_side.angle == ANG_FORTY_FIVE)
                 || (i_side.angle == ANG_SIXTY);

    // pick pass-through or clamped diagonal result
    logic signed [COORD_W-1:0] n_x, n_y;
    logic                      n_sat;

    always_comb begin
        n_x   = i_side.base_x;
        n_y   = i_side.base_y;
        n_sat = 1'b0;
        if (w_diag) begin
            priority if (w_hi_x) n_x = LIM_HI[COORD_W-1:0];
            else if (w_lo_x)     n_x = LIM_LO[COORD_W-1:0];
            else                 n_x = w_sum_x[COORD_W-1:0];
            priority if (w_hi_y) n_y = LIM_HI[COORD_W-1:0];
            else if (w_lo_y)     n_y = LIM_LO[COORD_W-1:0];
            else                 n_y = w_sum_y[COORD_W-1:0];
            n_sat = w_hi_x || w_lo_x || w_hi_y || w_lo_y;
        end
    end

    logic signed [COORD_W-1:0] r_x, r_y;
    t_angle                    r_angle;
    logic                      r_sat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_angle <= i_side.angle;
            r_sat   <= n_sat;
        end
    end

    assign o_snapped_x    = r_x;
    assign o_snapped_y    = r_y;
    assign o_chosen_angle = r_angle;
    assign o_saturated    = r_sat;

endmodule

>>> hw/rtl/line_angle_snap_unit.sv
// Top level of the line end point angle snapper.
// Takes one request per cycle while no stall backs up to the input, and returns one result
// per request, in order: three front stages form the deltas, the slope products and the
// angle decision, the two-lane square root resolves two root bits per stage (SQ_STAGES =
// ceil((COORD_W + 2) / 2)), and one stage rounds, signs and clamps. Every stage holds its
// own valid bit, so a stall on the output only backs up as far as the first empty stage.
// With both snap flags low the end point passes through; horizontal and vertical snaps
// never set saturated.
module line_angle_snap_unit
    import las_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic                      i_snap_forty_five,
    input  logic                      i_snap_thirty_sixty,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_snapped_x,
    output logic signed [COORD_W-1:0] o_snapped_y,
    output logic [2:0]                o_chosen_angle,
    output logic                      o_saturated
);

    // front stages to square root
    logic             w_pv, w_pr;
    logic [RAD_W-1:0] w_rad_x, w_rad_y;
    t_side            w_pside;

    las_prep u_prep (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_start_x           (i_start_x),
        .i_start_y           (i_start_y),
        .i_end_x             (i_end_x),
        .i_end_y             (i_end_y),
        .i_snap_forty_five   (i_snap_forty_five),
        .i_snap_thirty_sixty (i_snap_thirty_sixty),
        .o_valid             (w_pv),
        .i_ready             (w_pr),
        .o_rad_x             (w_rad_x),
        .o_rad_y             (w_rad_y),
        .o_side              (w_pside)
    );

    // square root to output stage
    logic              w_qv, w_qr;
    logic [ROOT_W-1:0] w_root_x, w_root_y;
    t_side             w_qside;

    las_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pv),
        .o_ready  (w_pr),
        .i_rad_x  (w_rad_x),
        .i_rad_y  (w_rad_y),
        .i_side   (w_pside),
        .o_valid  (w_qv),
        .i_ready  (w_qr),
        .o_root_x (w_root_x),
        .o_root_y (w_root_y),
        .o_side   (w_qside)
    );

    las_finish u_finish (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_qv),
        .o_ready        (w_qr),
        .i_root_x       (w_root_x),
        .i_root_y       (w_root_y),
        .i_side         (w_qside),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_snapped_x    (o_snapped_x),
        .o_snapped_y    (o_snapped_y),
        .o_chosen_angle (o_chosen_angle),
        .o_saturated    (o_saturated)
    );

`ifndef SYNTHESIS
    // input can only back up when a finished result is held at the output
    a_stall_source: assert property (@(posedge i_clk)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a held result");

    // clamping only happens on diagonal snaps
    a_sat_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> ((o_chosen_angle == ANG_THIRTY)
            || (o_chosen_angle == ANG_FORTY_FIVE) || (o_chosen_angle == ANG_SIXTY)))
        else $error("saturated set on a non-diagonal result");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the line end point angle snapper.
module tb;
    import las_pkg::*;

    typedef logic signed [COORD_W-1:0] t_coord;

    // one predicted snap result
    typedef struct {
        t_coord x;
        t_coord y;
        t_angle ang;
        logic   sat;
    } t_snap_res;

    localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
    localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    t_coord i_start_x = '0;
    t_coord i_start_y = '0;
    t_coord i_end_x = '0;
    t_coord i_end_y = '0;
    logic   i_snap_forty_five = 1'b0;
    logic   i_snap_thirty_sixty = 1'b0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_coord o_snapped_x;
    t_coord o_snapped_y;
    logic [2:0] o_chosen_angle;
    logic   o_saturated;

    t_snap_res expected_snaps[$];
    int        mismatches = 0;
    int        requests_sent = 0;
    int        results_seen = 0;
    int        angle_hits[6];
    bit        idle_on = 1'b0;
    int        ready_hold = 0;

    line_angle_snap_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_start_x           (i_start_x),
        .i_start_y           (i_start_y),
        .i_end_x             (i_end_x),
        .i_end_y             (i_end_y),
        .i_snap_forty_five   (i_snap_forty_five),
        .i_snap_thirty_sixty (i_snap_thirty_sixty),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_snapped_x         (o_snapped_x),
        .o_snapped_y         (o_snapped_y),
        .o_chosen_angle      (o_chosen_angle),
        .o_saturated         (o_saturated)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bit-serial floor square root
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem = v;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // tangent of the midpoint between two neighboring angles, Q(FRAC_BITS)
    function automatic longint unsigned mid_slope(input t_angle lo, input t_angle hi);
        longint unsigned one;
        longint unsigned r2;
        longint unsigned r3;
        longint unsigned r6;
        longint unsigned t;
        one = 64'd1 << 30;
        r2 = floor_sqrt(64'd2 << 60);
        r3 = floor_sqrt(64'd3 << 60);
        r6 = floor_sqrt(64'd6 << 60);
        if (lo == ANG_HORZ && hi == ANG_THIRTY)
            t = 2 * one - r3;
        else if (lo == ANG_HORZ && hi == ANG_FORTY_FIVE)
            t = r2 - one;
        else if (lo == ANG_THIRTY && hi == ANG_FORTY_FIVE)
            t = (r6 + r3) - (r2 + 2 * one);
        else if (lo == ANG_THIRTY && hi == ANG_SIXTY)
            t = one;
        else if (lo == ANG_FORTY_FIVE && hi == ANG_SIXTY)
            t = (r6 + 2 * one) - (r2 + r3);
        else if (lo == ANG_FORTY_FIVE && hi == ANG_VERT)
            t = r2 + one;
        else
            t = 2 * one + r3;
        return (t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    // expected snap of one request
    function automatic t_snap_res predict_snap(input t_coord sx, input t_coord sy,
                                               input t_coord ex, input t_coord ey,
                                               input logic f45, input logic f3060);
        t_snap_res       r;
        longint          dx;
        longint          dy;
        longint          kx;
        longint          ky;
        longint          v[2];
        longint unsigned a;
        longint unsigned b;
        longint unsigned s;
        longint unsigned x4;
        longint unsigned y4;
        t_angle          allowed[5];
        int              n;
        int              i;
        bit              found;
        r.x = ex;
        r.y = ey;
        r.ang = ANG_NONE;
        r.sat = 1'b0;
        if (!(f45 || f3060))
            return r;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        b = (dx < 0) ? -dx : dx;
        a = (dy < 0) ? -dy : dy;

        // allowed angles in ascending order
        n = 0;
        allowed[n] = ANG_HORZ;
        n++;
        if (f3060) begin
            allowed[n] = ANG_THIRTY;
            n++;
        end
        if (f45) begin
            allowed[n] = ANG_FORTY_FIVE;
            n++;
        end
        if (f3060) begin
            allowed[n] = ANG_SIXTY;
            n++;
        end
        allowed[n] = ANG_VERT;
        n++;

        // first angle whose upper midpoint slope exceeds |dy|/|dx|
        r.ang = allowed[n-1];
        found = 1'b0;
        for (i = 0; i < n - 1; i++) begin
            if (!found && (a << FRAC_BITS) < mid_slope(allowed[i], allowed[i+1]) * b) begin
                r.ang = allowed[i];
                found = 1'b1;
            end
        end

        case (r.ang)
            ANG_HORZ: begin
                r.y = sy;
            end
            ANG_VERT: begin
                r.x = sx;
            end
            default: begin
                // length-preserving diagonal, round half up, then clamp
                s = a * a + b * b;
                if (r.ang == ANG_THIRTY) begin
                    x4 = 3 * s;
                    y4 = s;
                end else if (r.ang == ANG_FORTY_FIVE) begin
                    x4 = 2 * s;
                    y4 = 2 * s;
                end else begin
                    x4 = s;
                    y4 = 3 * s;
                end
                kx = longint'((floor_sqrt(x4) + 1) >> 1);
                ky = longint'((floor_sqrt(y4) + 1) >> 1);
                if (dx < 0)
                    kx = -kx;
                if (dy < 0)
                    ky = -ky;
                v[0] = longint'(sx) + kx;
                v[1] = longint'(sy) + ky;
                for (i = 0; i < 2; i++) begin
                    if (v[i] < COORD_MIN) begin
                        v[i] = COORD_MIN;
                        r.sat = 1'b1;
                    end else if (v[i] > COORD_MAX) begin
                        v[i] = COORD_MAX;
                        r.sat = 1'b1;
                    end
                end
                r.x = v[0][COORD_W-1:0];
                r.y = v[1][COORD_W-1:0];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH %0d at result %0d: %s got %0d want %0d",
                 mismatches, results_seen, what, got, want);
    endtask

    // drive one request and log its prediction when it is taken
    task automatic send_req(input t_coord sx, input t_coord sy, input t_coord ex,
                            input t_coord ey, input logic f45, input logic f3060);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        i_snap_forty_five <= f45;
        i_snap_thirty_sixty <= f3060;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        expected_snaps.push_back(predict_snap(sx, sy, ex, ey, f45, f3060));
        requests_sent++;
    endtask

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    // start/end pair on one axis with the given delta magnitude, random direction
    task automatic place(input int mag, output t_coord s, output t_coord e);
        int base;
        if ($urandom_range(0, 1)) begin
            base = int'($urandom_range(0, 32767 - mag)) - 16384;
            e = t_coord'(base + mag);
        end else begin
            base = int'($urandom_range(mag, 32767)) - 16384;
            e = t_coord'(base - mag);
        end
        s = t_coord'(base);
    endtask

    // output side: stall in random bursts while idling is enabled
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_snap_res want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_snaps.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = expected_snaps.pop_front();
                angle_hits[want.ang]++;
                if (o_snapped_x !== want.x)
                    report_mismatch("snapped_x", o_snapped_x, want.x);
                if (o_snapped_y !== want.y)
                    report_mismatch("snapped_y", o_snapped_y, want.y);
                if (o_chosen_angle !== want.ang)
                    report_mismatch("chosen_angle", o_chosen_angle, want.ang);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    // flags clear: end point passes through
    task automatic test_passthrough();
        send_req(-16384, -16384, 16383, 16383, 1'b0, 1'b0);
        send_req(16383, 16383, -16384, -16384, 1'b0, 1'b0);
        send_req(0, 0, 12345, -9876, 1'b0, 1'b0);
    endtask

    // horizontal and vertical snaps, zero dx and zero length
    task automatic test_axis_snaps();
        send_req(100, -200, 100, -200, 1'b1, 1'b0);
        send_req(100, -200, 100, -200, 1'b0, 1'b1);
        send_req(100, -200, 100, -200, 1'b1, 1'b1);
        send_req(5, 5, 5, -16384, 1'b1, 1'b1);
        send_req(-16384, 7, 16383, 7, 1'b1, 1'b0);
        send_req(-16384, 7, 16383, 7, 1'b0, 1'b1);
        send_req(16383, 7, -16384, 7, 1'b1, 1'b1);
        send_req(0, 0, 1000, 100, 1'b1, 1'b1);
        send_req(0, 0, -100, -1000, 1'b1, 1'b0);
    endtask

    // diagonal snaps: signs, exact 45, slope boundaries and clamping
    task automatic test_diagonals();
        send_req(0, 0, 1000, 1000, 1'b1, 1'b0);
        send_req(0, 0, 1000, 1000, 1'b0, 1'b1);
        send_req(0, 0, -577, 1000, 1'b1, 1'b1);
        send_req(0, 0, 1000, -577, 1'b1, 1'b1);
        send_req(0, 0, -1000, -1000, 1'b1, 1'b1);
        send_req(0, 0, 1000, 414, 1'b1, 1'b0);
        send_req(0, 0, 1000, 415, 1'b1, 1'b0);
        send_req(-16384, -16384, 16383, 16383, 1'b1, 1'b0);
        send_req(16383, 16383, -16384, -16384, 1'b1, 1'b0);
        send_req(16383, -16384, -16384, 16383, 1'b0, 1'b1);
        send_req(0, 0, 16383, 16000, 1'b1, 1'b1);
    endtask

    // random mix of full-range, short and medium lines, idling switched per block
    task automatic test_random_mix(input int count);
        t_coord sx, sy, ex, ey;
        logic   f45, f3060;
        int     combo;
        int     kind;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                combo = 0;
            end else begin
                combo = $urandom_range(1, 3);
            end
            f45 = combo[0];
            f3060 = combo[1];
            kind = $urandom_range(0, 2);
            if (kind == 0) begin
                sx = rand_coord();
                sy = rand_coord();
                ex = rand_coord();
                ey = rand_coord();
            end else begin
                place($urandom_range(0, (kind == 1) ? 64 : 4000), sx, ex);
                place($urandom_range(0, (kind == 1) ? 64 : 4000), sy, ey);
            end
            send_req(sx, sy, ex, ey, f45, f3060);
        end
    endtask

    // slopes within one step of a decision threshold
    task automatic test_random_boundary(input int count);
        t_coord          sx, sy, ex, ey;
        logic            f45, f3060;
        t_angle          lo, hi;
        longint unsigned thr;
        int              b;
        int              a;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 6))
                0: begin
                    lo = ANG_HORZ; hi = ANG_THIRTY;
                    f3060 = 1'b1; f45 = 1'($urandom_range(0, 1));
                end
                1: begin
                    lo = ANG_HORZ; hi = ANG_FORTY_FIVE;
                    f3060 = 1'b0; f45 = 1'b1;
                end
                2: begin
                    lo = ANG_THIRTY; hi = ANG_FORTY_FIVE;
                    f3060 = 1'b1; f45 = 1'b1;
                end
                3: begin
                    lo = ANG_THIRTY; hi = ANG_SIXTY;
                    f3060 = 1'b1; f45 = 1'b0;
                end
                4: begin
                    lo = ANG_FORTY_FIVE; hi = ANG_SIXTY;
                    f3060 = 1'b1; f45 = 1'b1;
                end
                5: begin
                    lo = ANG_FORTY_FIVE; hi = ANG_VERT;
                    f3060 = 1'b0; f45 = 1'b1;
                end
                default: begin
                    lo = ANG_SIXTY; hi = ANG_VERT;
                    f3060 = 1'b1; f45 = 1'($urandom_range(0, 1));
                end
            endcase
            thr = mid_slope(lo, hi);
            b = $urandom_range(1, 8000);
            a = int'((thr * longint'(b)) >> FRAC_BITS) + int'($urandom_range(0, 2)) - 1;
            if (a < 0)
                a = 0;
            if (a > 32767)
                a = 32767;
            place(b, sx, ex);
            place(a, sy, ey);
            send_req(sx, sy, ex, ey, f45, f3060);
        end
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate(input int count);
        for (int k = 0; k < count; k++)
            send_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     1'(($urandom_range(0, 3) != 0)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int wait_cycles;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        test_passthrough();
        test_axis_snaps();
        test_diagonals();
        test_random_mix(1000);
        idle_on = 1'b1;
        test_random_boundary(200);
        idle_on = 1'b0;
        test_full_rate(100);
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then let the pipeline settle
        wait_cycles = 0;
        while (expected_snaps.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (30) @(posedge i_clk);
        if (expected_snaps.size() != 0)
            report_mismatch("results never returned", 0, expected_snaps.size());

        $display("Ran %0d snap requests, %0d results checked, %0d mismatches.",
                 requests_sent, results_seen, mismatches);
        $display("Angles seen: none %0d, horz %0d, 30 %0d, 45 %0d, 60 %0d, vert %0d.",
                 angle_hits[0], angle_hits[1], angle_hits[2],
                 angle_hits[3], angle_hits[4], angle_hits[5]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("Watchdog expired with %0d results pending.", expected_snaps.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/las_pkg.sv
hw/rtl/las_prep.sv
hw/rtl/las_sqrt.sv
hw/rtl/las_finish.sv
hw/rtl/line_angle_snap_unit.sv
tb/sv/tb.sv
